FILE: rtl/jsu_pkg.sv
// ============================================================================
// jsu_pkg
// Shared types and codes for the JSON string unescape block: result status
// codes, parser mode codes and the byte values the parser looks for.
// ============================================================================
package jsu_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] status_t;
    typedef logic [2:0] mode_t;

    // Result status codes
    localparam status_t ST_DATA     = 3'd0;
    localparam status_t ST_CLOSED   = 3'd1;
    localparam status_t ST_CONTROL  = 3'd2;
    localparam status_t ST_TRAILING = 3'd3;
    localparam status_t ST_BAD_HEX  = 3'd4;
    localparam status_t ST_LONE     = 3'd5;
    localparam status_t ST_BAD_ESC  = 3'd6;
    localparam status_t ST_UNTERM   = 3'd7;

    // Parser modes
    localparam mode_t MODE_NORMAL        = 3'd0;
    localparam mode_t MODE_ESC           = 3'd1;
    localparam mode_t MODE_HEX1          = 3'd2;
    localparam mode_t MODE_AFTER_HIGH    = 3'd3;
    localparam mode_t MODE_AFTER_HIGH_BS = 3'd4;
    localparam mode_t MODE_HEX2          = 3'd5;

    // Characters of interest
    localparam byte_t CH_QUOTE     = 8'h22;
    localparam byte_t CH_BACKSLASH = 8'h5C;
    localparam byte_t CH_SLASH     = 8'h2F;
    localparam byte_t CH_LOWER_B   = 8'h62;
    localparam byte_t CH_LOWER_F   = 8'h66;
    localparam byte_t CH_LOWER_N   = 8'h6E;
    localparam byte_t CH_LOWER_R   = 8'h72;
    localparam byte_t CH_LOWER_T   = 8'h74;
    localparam byte_t CH_LOWER_U   = 8'h75;
    localparam byte_t CH_SPACE     = 8'h20;

    // Surrogate prefixes (top six bits of a 16-bit code unit)
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    // Maximum result beats per input beat
    localparam int unsigned MAX_RESULTS = 4;

endpackage

FILE: rtl/jsu_in_if.sv
// ============================================================================
// jsu_in_if
// Input channel of the JSON string unescape block: one body byte or an
// end-of-input marker per beat, with a valid/ready handshake.
// ============================================================================
interface jsu_in_if;
    import jsu_pkg::*;

    logic  valid;
    logic  ready;
    logic  action;
    byte_t data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink   (input valid, input action, input data_byte, output ready);

endinterface

FILE: rtl/jsu_out_if.sv
// ============================================================================
// jsu_out_if
// Result channel of the JSON string unescape block: one decoded byte or one
// status event per beat, with a valid/ready handshake.
// ============================================================================
interface jsu_out_if;
    import jsu_pkg::*;

    logic    valid;
    logic    ready;
    byte_t   out_byte;
    status_t status;
    logic    last_of_run;

    modport source (output valid, output out_byte, output status, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last_of_run,
                    output ready);

endinterface

FILE: rtl/json_string_unescape.sv
// ============================================================================
// json_string_unescape
// Streaming decoder for the body of a JSON string, emitting UTF-8 bytes and
// closed / error status beats.
// ============================================================================
// Feed the bytes after the opening quote, one per input beat, and an
// end-of-input beat (action = 1) if the stream ends. Every input beat is
// decoded in the cycle it is accepted and its results (none to four) are
// loaded into a four-entry result buffer, which drains one beat per cycle
// while the sink is ready. Input is taken whenever the buffer is empty or
// its final beat leaves in the same cycle, so ordinary text runs at one
// byte per cycle when the sink is ready; the last hex digit of a \u escape
// that yields two, three or four UTF-8 bytes holds off further input until
// the buffer has drained. Every closed or error beat carries out_byte = 0
// and last_of_run = 1, and leaves the parser back in normal text mode.
// ============================================================================
module json_string_unescape
(
    input  logic      clk,
    input  logic      rst_n,
    jsu_in_if.sink    in_ch,
    jsu_out_if.source out_ch
);
    import jsu_pkg::*;

    // Parser state
    mode_t       mode_reg,  mode_next;
    logic [15:0] hex_reg,   hex_next;
    logic [1:0]  dcnt_reg,  dcnt_next;
    logic [9:0]  high_reg,  high_next;

    // Result buffer
    byte_t       buf_reg [MAX_RESULTS];
    status_t     stat_reg;
    logic [2:0]  cnt_reg;
    logic [1:0]  idx_reg;

    // Decode results for the current input beat
    byte_t       res_b [MAX_RESULTS];
    status_t     res_st;
    logic [2:0]  res_n;

    logic        in_fire;
    logic        out_fire;
    logic        at_end;
    byte_t       b;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] hex_acc;
    logic        err;
    status_t     err_code;
    logic        emit;
    logic [20:0] cp;
    logic        clr;

    assign at_end   = in_ch.action;
    assign b        = in_ch.data_byte;
    assign out_fire = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_ch.ready);
    assign in_fire  = in_ch.valid && in_ch.ready;

    // Hex digit decode
    always_comb
    begin
        hex_ok = 1'b1;
        hex_d  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            hex_d = b[3:0];
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            hex_d = b[3:0] + 4'd9;
        end
        else
        begin
            hex_ok = 1'b0;
        end
    end

    assign hex_acc = {hex_reg[11:0], hex_d};

    // Parser next state and result selection
    always_comb
    begin
        mode_next = mode_reg;
        hex_next  = hex_reg;
        dcnt_next = dcnt_reg;
        high_next = high_reg;
        err       = 1'b0;
        err_code  = ST_DATA;
        emit      = 1'b0;
        cp        = 21'd0;
        clr       = 1'b0;
        res_st    = ST_DATA;
        res_n     = 3'd0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            res_b[i] = 8'h00;
        end

        case (mode_reg)
            MODE_NORMAL:
            begin
                if (at_end)
                begin
                    err = 1'b1; err_code = ST_UNTERM;
                end
                else if (b == CH_QUOTE)
                begin
                    err = 1'b1; err_code = ST_CLOSED;
                end
                else if (b < CH_SPACE)
                begin
                    err = 1'b1; err_code = ST_CONTROL;
                end
                else if (b == CH_BACKSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    res_n    = 3'd1;
                    res_b[0] = b;
                end
            end
            MODE_ESC:
            begin
                if (at_end)
                begin
                    err = 1'b1; err_code = ST_TRAILING;
                end
                else
                begin
                    mode_next = MODE_NORMAL;
                    res_n     = 3'd1;
                    case (b)
                        CH_QUOTE, CH_BACKSLASH, CH_SLASH: res_b[0] = b;
                        CH_LOWER_B: res_b[0] = 8'h08;
                        CH_LOWER_F: res_b[0] = 8'h0C;
                        CH_LOWER_N: res_b[0] = 8'h0A;
                        CH_LOWER_R: res_b[0] = 8'h0D;
                        CH_LOWER_T: res_b[0] = 8'h09;
                        CH_LOWER_U:
                        begin
                            res_n     = 3'd0;
                            mode_next = MODE_HEX1;
                            hex_next  = 16'd0;
                            dcnt_next = 2'd0;
                        end
                        default:
                        begin
                            res_n = 3'd0;
                            err = 1'b1; err_code = ST_BAD_ESC;
                        end
                    endcase
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (at_end || !hex_ok)
                begin
                    err = 1'b1; err_code = ST_BAD_HEX;
                end
                else
                begin
                    hex_next = hex_acc;
                    if (dcnt_reg != 2'd3)
                    begin
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                    else if (mode_reg == MODE_HEX1)
                    begin
                        dcnt_next = 2'd0;
                        if (hex_acc[15:10] == SURR_HIGH)
                        begin
                            high_next = hex_acc[9:0];
                            hex_next  = 16'd0;
                            mode_next = MODE_AFTER_HIGH;
                        end
                        else if (hex_acc[15:10] == SURR_LOW)
                        begin
                            err = 1'b1; err_code = ST_LONE;
                        end
                        else
                        begin
                            clr  = 1'b1;
                            emit = 1'b1;
                            cp   = {5'd0, hex_acc};
                        end
                    end
                    else
                    begin
                        dcnt_next = 2'd0;
                        if (hex_acc[15:10] != SURR_LOW)
                        begin
                            err = 1'b1; err_code = ST_LONE;
                        end
                        else
                        begin
                            clr  = 1'b1;
                            emit = 1'b1;
                            cp   = 21'h10000 + {1'b0, high_reg, hex_acc[9:0]};
                        end
                    end
                end
            end
            MODE_AFTER_HIGH:
            begin
                if (at_end || b != CH_BACKSLASH)
                begin
                    err = 1'b1; err_code = ST_LONE;
                end
                else
                begin
                    mode_next = MODE_AFTER_HIGH_BS;
                end
            end
            MODE_AFTER_HIGH_BS:
            begin
                if (at_end || b != CH_LOWER_U)
                begin
                    err = 1'b1; err_code = ST_LONE;
                end
                else
                begin
                    mode_next = MODE_HEX2;
                    hex_next  = 16'd0;
                    dcnt_next = 2'd0;
                end
            end
            default:
            begin
                clr = 1'b1;
            end
        endcase

        // UTF-8 encode a completed code point
        if (emit)
        begin
            if (cp < 21'h80)
            begin
                res_n    = 3'd1;
                res_b[0] = cp[7:0];
            end
            else if (cp < 21'h800)
            begin
                res_n    = 3'd2;
                res_b[0] = {3'b110, cp[10:6]};
                res_b[1] = {2'b10, cp[5:0]};
            end
            else if (cp < 21'h10000)
            begin
                res_n    = 3'd3;
                res_b[0] = {4'b1110, cp[15:12]};
                res_b[1] = {2'b10, cp[11:6]};
                res_b[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                res_n    = 3'd4;
                res_b[0] = {5'b11110, cp[20:18]};
                res_b[1] = {2'b10, cp[17:12]};
                res_b[2] = {2'b10, cp[11:6]};
                res_b[3] = {2'b10, cp[5:0]};
            end
        end

        // Report an error or close as a single status beat
        if (err)
        begin
            clr      = 1'b1;
            res_n    = 3'd1;
            res_st   = err_code;
            res_b[0] = 8'h00;
        end

        if (clr)
        begin
            mode_next = MODE_NORMAL;
            hex_next  = 16'd0;
            dcnt_next = 2'd0;
            high_next = 10'd0;
        end
    end

    // Advance parser state on each accepted input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            hex_reg  <= 16'd0;
            dcnt_reg <= 2'd0;
            high_reg <= 10'd0;
        end
        else if (in_fire)
        begin
            mode_reg <= mode_next;
            hex_reg  <= hex_next;
            dcnt_reg <= dcnt_next;
            high_reg <= high_next;
        end
    end

    // Result buffer control: load on input, drain one beat per cycle while the sink is ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
            idx_reg <= 2'd0;
        end
        else if (in_fire)
        begin
            cnt_reg <= res_n;
            idx_reg <= 2'd0;
        end
        else if (out_fire)
        begin
            cnt_reg <= cnt_reg - 3'd1;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Result buffer payload
    always_ff @(posedge clk)
    begin
        if (in_fire && (res_n != 3'd0))
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                buf_reg[i] <= res_b[i];
            end
            stat_reg <= res_st;
        end
    end

    assign out_ch.valid       = (cnt_reg != 3'd0);
    assign out_ch.out_byte    = buf_reg[idx_reg];
    assign out_ch.status      = stat_reg;
    assign out_ch.last_of_run = (cnt_reg == 3'd1);

    // Checks
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result count out of range");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_DATA) |-> out_ch.last_of_run)
        else $error("status beat is not the last of its run");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.status != ST_DATA) |-> (out_ch.out_byte == 8'h00))
        else $error("status beat carries a nonzero byte");

    a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && err) |=> (mode_reg == MODE_NORMAL && dcnt_reg == 2'd0))
        else $error("parser not back in normal mode after a status beat");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (cnt_reg == 3'd0 || out_fire))
        else $error("input accepted over undelivered results");

endmodule
